// ===== src/xt_pkg.sv =====
// shared constants and types for the binary xor trie
package xt_pkg;

	localparam int KEY_WIDTH  = 32;
	localparam int NODE_COUNT = 65536;
	localparam int NODE_BITS  = $clog2(NODE_COUNT);
	localparam int KB_BITS    = 6;
	localparam int CNT_BITS   = 32;

	localparam logic [KB_BITS-1:0]  KEY_BITS_RESET = KB_BITS'(30);
	localparam logic [KB_BITS-1:0]  KEY_WIDTH_W    = KB_BITS'(KEY_WIDTH);
	localparam logic [CNT_BITS-1:0] CNT_MAX        = '1;

	localparam logic [2:0] OP_INSERT  = 3'd0;
	localparam logic [2:0] OP_ERASE   = 3'd1;
	localparam logic [2:0] OP_MAX_XOR = 3'd2;
	localparam logic [2:0] OP_CNT_LT  = 3'd3;
	localparam logic [2:0] OP_CNT_GT  = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	typedef struct packed {
		logic [NODE_BITS-1:0] link;
		logic [CNT_BITS-1:0]  cnt;
	} edge_t;

	typedef edge_t [1:0] row_t;

endpackage

// ===== src/xt_if.sv =====
// handshake channels for items and results
interface xt_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [31:0] key;
	logic [31:0] bound;
	modport source (output valid, opcode, key, bound, input ready);
	modport sink   (input valid, opcode, key, bound, output ready);
endinterface

interface xt_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] answer;
	logic [1:0]  status;
	modport source (output valid, answer, status, input ready);
	modport sink   (input valid, answer, status, output ready);
endinterface

// ===== src/binary_xor_trie.sv =====
// binary xor trie: insert, erase, max xor and bounded xor counts over a node pool
// One operation at a time. The trie lives in a node memory of NODE_COUNT rows,
// each row holding both edges of a node (child link and pass-through count),
// with one read and one write port. Each trie level reads the current node,
// then evaluates and writes back. With w the walked width (key_bits clamped to
// 1..32), max xor and the counts walk up to w levels; erase a check walk and,
// if the key is present, an update walk; insert a check walk, a pool check, an
// update walk if there is room, and one extra write that zeroes a leaf node
// freshly taken from the pool. Unused opcodes go straight to the output state.
// The input is taken only while the walker is idle; a finished result sits in
// the output register, so the next item may enter before the previous result
// has been transferred. Nodes are never given back. There is no clearing pass
// after reset: only the root row needs a known value, and it reads as zero
// until first written; every other row is written before any walk can reach
// it. key_bits may only be written while the block is idle.
module binary_xor_trie (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [xt_pkg::KB_BITS-1:0] cfg_wdata,
	xt_in_if.sink                    in_ch,
	xt_out_if.source                 out_ch
);
	import xt_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_EV   = 6'b000100,
		S_CHK  = 6'b001000,
		S_ZERO = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;

	// node memory
	row_t mem [NODE_COUNT];
	row_t rd_q;

	// item and walk registers
	logic [2:0]           op_q;
	logic [31:0]          key_q;
	logic [31:0]          bound_q;
	logic [KB_BITS-1:0]   k_q;        // levels still to walk
	logic [NODE_BITS-1:0] j_q;        // current node
	logic                 fresh_q;    // current node just taken from the pool
	logic                 pass_q;     // 0 check walk, 1 update walk
	logic [KB_BITS-1:0]   needed_q;
	logic [NODE_BITS-1:0] zaddr_q;
	logic [31:0]          acc_q;
	logic [1:0]           status_q;
	logic [NODE_BITS:0]   nodes_used_q;
	logic [KB_BITS-1:0]   key_bits_q;
	logic                 root_wr_q;
	logic                 out_valid_q;
	logic [31:0]          out_answer_q;
	logic [1:0]           out_status_q;

	// evaluation of one level
	logic [KB_BITS-1:0]   width_c;
	logic [4:0]           bi_c;
	logic                 kb_c, lb_c, b_c, last_c;
	row_t                 row_c, wrow_c;
	edge_t                eb_c, eo_c, upd_c;
	logic                 created_c;
	logic [NODE_BITS-1:0] ins_link_c;
	logic [CNT_BITS-1:0]  dec_c;
	logic [CNT_BITS:0]    sum_c;
	logic                 mem_we_c;
	logic [NODE_BITS-1:0] mem_waddr_c;
	row_t                 mem_wdata_c;

	// out-of-range key_bits clamp to 1..KEY_WIDTH
	assign width_c = (key_bits_q == '0) ? KB_BITS'(1) :
		((key_bits_q > KEY_WIDTH_W) ? KEY_WIDTH_W : key_bits_q);

	always_comb begin
		bi_c   = 5'(k_q - KB_BITS'(1));
		kb_c   = key_q[bi_c];
		lb_c   = bound_q[bi_c];
		last_c = (k_q == KB_BITS'(1));
		// count queries follow the branch that keeps key^y equal to the bound
		b_c    = (op_q == OP_CNT_LT || op_q == OP_CNT_GT) ? (lb_c ^ kb_c) : kb_c;
		// a fresh node and an unwritten root both read as empty
		row_c  = (fresh_q || (j_q == '0 && !root_wr_q)) ? row_t'('0) : rd_q;
		eb_c   = row_c[b_c];
		eo_c   = row_c[~b_c];
		created_c  = (eb_c.link == '0);
		ins_link_c = created_c ? nodes_used_q[NODE_BITS-1:0] : eb_c.link;
		dec_c      = eb_c.cnt - CNT_BITS'(1);
		sum_c      = {1'b0, acc_q} + {1'b0, eo_c.cnt};
		upd_c      = eb_c;
		if (op_q == OP_INSERT) begin
			upd_c.link = ins_link_c;
			upd_c.cnt  = (eb_c.cnt == CNT_MAX) ? CNT_MAX : eb_c.cnt + CNT_BITS'(1);
		end else begin
			upd_c.cnt  = dec_c;
			upd_c.link = (dec_c == '0) ? NODE_BITS'(0) : eb_c.link;
		end
		wrow_c      = row_c;
		wrow_c[b_c] = upd_c;
	end

	// write port: update walk of insert or erase, or zeroing a new leaf
	always_comb begin
		mem_we_c    = 1'b0;
		mem_waddr_c = j_q;
		mem_wdata_c = wrow_c;
		if (state_q == S_EV && pass_q && (op_q == OP_INSERT || op_q == OP_ERASE)) begin
			mem_we_c = 1'b1;
		end else if (state_q == S_ZERO) begin
			mem_we_c    = 1'b1;
			mem_waddr_c = zaddr_q;
			mem_wdata_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we_c) begin
			mem[mem_waddr_c] <= mem_wdata_c;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RD) begin
			rd_q <= mem[j_q];
		end
	end

	assign in_ch.ready   = (state_q == S_IDLE);
	assign out_ch.valid  = out_valid_q;
	assign out_ch.answer = out_answer_q;
	assign out_ch.status = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			key_bits_q   <= KEY_BITS_RESET;
			nodes_used_q <= (NODE_BITS+1)'(1);
			root_wr_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			out_answer_q <= '0;
			out_status_q <= ST_OK;
			op_q         <= OP_INSERT;
			key_q        <= '0;
			bound_q      <= '0;
			k_q          <= '0;
			j_q          <= '0;
			fresh_q      <= 1'b0;
			pass_q       <= 1'b0;
			needed_q     <= '0;
			zaddr_q      <= '0;
			acc_q        <= '0;
			status_q     <= ST_OK;
		end else begin
			if (cfg_we) begin
				key_bits_q <= cfg_wdata;
			end
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (mem_we_c && mem_waddr_c == '0) begin
				root_wr_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						op_q     <= in_ch.opcode;
						key_q    <= in_ch.key;
						bound_q  <= in_ch.bound;
						k_q      <= width_c;
						j_q      <= '0;
						fresh_q  <= 1'b0;
						pass_q   <= 1'b0;
						acc_q    <= '0;
						status_q <= ST_OK;
						if (in_ch.opcode == OP_INSERT || in_ch.opcode == OP_ERASE ||
							in_ch.opcode == OP_MAX_XOR || in_ch.opcode == OP_CNT_LT ||
							in_ch.opcode == OP_CNT_GT) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					state_q <= S_RD;
					k_q     <= k_q - KB_BITS'(1);
					fresh_q <= 1'b0;
					priority if (op_q == OP_INSERT && !pass_q) begin
						j_q <= eb_c.link;
						if (created_c) begin
							needed_q <= k_q;
							state_q  <= S_CHK;
						end else if (last_c) begin
							needed_q <= '0;
							state_q  <= S_CHK;
						end
					end else if (op_q == OP_INSERT) begin
						j_q     <= ins_link_c;
						fresh_q <= created_c;
						if (created_c) begin
							nodes_used_q <= nodes_used_q + (NODE_BITS+1)'(1);
						end
						zaddr_q <= ins_link_c;
						if (last_c) begin
							state_q <= created_c ? S_ZERO : S_OUT;
						end
					end else if (op_q == OP_ERASE && !pass_q) begin
						j_q <= eb_c.link;
						if (eb_c.link == '0 || eb_c.cnt == '0) begin
							status_q <= ST_ABSENT;
							state_q  <= S_OUT;
						end else if (last_c) begin
							// path is whole: restart from the root and update
							pass_q <= 1'b1;
							k_q    <= width_c;
							j_q    <= '0;
						end
					end else if (op_q == OP_ERASE) begin
						j_q <= eb_c.link;
						if (last_c) begin
							state_q <= S_OUT;
						end
					end else if (op_q == OP_MAX_XOR) begin
						if (eo_c.link != '0) begin
							acc_q <= acc_q | (32'd1 << bi_c);
							j_q   <= eo_c.link;
							if (last_c) state_q <= S_OUT;
						end else if (eb_c.link != '0) begin
							j_q <= eb_c.link;
							if (last_c) state_q <= S_OUT;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						// count less adds where the bound bit is one, greater where zero
						if ((op_q == OP_CNT_LT) == lb_c) begin
							acc_q <= sum_c[CNT_BITS] ? CNT_MAX : sum_c[CNT_BITS-1:0];
						end
						j_q <= eb_c.link;
						if (last_c || eb_c.link == '0) begin
							state_q <= S_OUT;
						end
					end
				end
				S_CHK: begin
					if ({1'b0, nodes_used_q} + (NODE_BITS+2)'(needed_q) >
						(NODE_BITS+2)'(NODE_COUNT)) begin
						status_q <= ST_FULL;
						state_q  <= S_OUT;
					end else begin
						pass_q  <= 1'b1;
						k_q     <= width_c;
						j_q     <= '0;
						fresh_q <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_ZERO: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q  <= 1'b1;
						out_answer_q <= acc_q;
						out_status_q <= status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_used_q <= (NODE_BITS+1)'(NODE_COUNT))
		else $error("node pool overrun");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EV |-> (k_q != '0 && k_q <= KEY_WIDTH_W))
		else $error("walk level out of range");

	a_write_when: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we_c |-> ((state_q == S_EV && pass_q) || state_q == S_ZERO))
		else $error("node memory written outside an update");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output state");
`endif

endmodule
